// ----- hdl/prqs_pkg.sv -----
// ---------------------------------------------------------------------------
// prqs_pkg
// Shared types, codes and defaults of the priority ready-queue scheduler.
// ---------------------------------------------------------------------------
package prqs_pkg;

    localparam int DEF_THREAD_SLOTS    = 8;
    localparam int DEF_PRIORITY_LEVELS = 16;

    // kernel call codes
    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_EXIT   = 3'd1;
    localparam logic [2:0] ACT_YIELD  = 3'd2;
    localparam logic [2:0] ACT_SLEEP  = 3'd3;
    localparam logic [2:0] ACT_WAKEUP = 3'd4;
    localparam logic [2:0] ACT_GETID  = 3'd5;
    localparam logic [2:0] ACT_CHPRI  = 3'd6;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOSLOT = 2'd1;
    localparam logic [1:0] STAT_HALT   = 2'd2;
    localparam logic [1:0] STAT_BADID  = 2'd3;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] priority_req;
        logic       priority_keep;
        logic [2:0] thread_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0] running_thread;
        logic       running_valid;
        logic [3:0] return_value;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_ENQ_RUN,
        S_ENQ_NEW,
        S_SEL
    } t_state;

    typedef enum logic [1:0] {
        SRC_RUN,
        SRC_NEW,
        SRC_TID
    } t_enq_src;

    typedef struct packed {
        logic     load;
        logic     deq;
        logic     enq;
        t_enq_src enq_src;
        logic     sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       run_ok;
        logic       halted;
        logic       other_ok;
        logic       out_free;
    } t_dp_status;

endpackage

// ----- hdl/prqs_ctrl.sv -----
// ---------------------------------------------------------------------------
// prqs_ctrl
// Sequencer of one kernel call: accept, dequeue, up to two enqueues, select.
// ---------------------------------------------------------------------------
module prqs_ctrl import prqs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   put_back;
    logic   second_enq;

    // caller goes back in its queue on these calls when a thread is running
    assign put_back = i_status.run_ok &&
                      (i_status.action == ACT_CREATE || i_status.action == ACT_YIELD ||
                       i_status.action == ACT_WAKEUP || i_status.action == ACT_GETID ||
                       i_status.action == ACT_CHPRI);
    assign second_enq = (i_status.action == ACT_CREATE) || (i_status.action == ACT_WAKEUP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.halted ? S_SEL : S_DEQ;
                end
            end
            S_DEQ: begin
                if (put_back) begin
                    n_state = S_ENQ_RUN;
                end else if (second_enq) begin
                    n_state = S_ENQ_NEW;
                end else begin
                    n_state = S_SEL;
                end
            end
            S_ENQ_RUN: begin
                n_state = second_enq ? S_ENQ_NEW : S_SEL;
            end
            S_ENQ_NEW: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.load    = 1'b0;
        o_cmd.deq     = 1'b0;
        o_cmd.enq     = 1'b0;
        o_cmd.enq_src = SRC_RUN;
        o_cmd.sel     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_DEQ: begin
                o_cmd.deq = 1'b1;
            end
            S_ENQ_RUN: begin
                o_cmd.enq     = 1'b1;
                o_cmd.enq_src = SRC_RUN;
            end
            S_ENQ_NEW: begin
                o_cmd.enq     = i_status.other_ok;
                o_cmd.enq_src = (i_status.action == ACT_CREATE) ? SRC_NEW : SRC_TID;
            end
            S_SEL: begin
                o_cmd.sel = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- hdl/prqs_datapath.sv -----
// ---------------------------------------------------------------------------
// prqs_datapath
// Thread slot table, linked ready queues, request and result registers.
// ---------------------------------------------------------------------------
module prqs_datapath import prqs_pkg::*; #(
    parameter int THREAD_SLOTS    = DEF_THREAD_SLOTS,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  logic       i_out_stall,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    localparam int SW = $clog2(THREAD_SLOTS);
    localparam int PW = $clog2(PRIORITY_LEVELS);

    t_in_item                   r_req;
    logic [3:0]                 r_ret;
    logic [1:0]                 r_stat;
    logic [SW-1:0]              r_new;
    logic                       r_found;
    logic [SW-1:0]              r_run;
    logic                       r_run_ok;
    logic                       r_halt;
    logic [THREAD_SLOTS-1:0]    r_used;
    logic [THREAD_SLOTS-1:0]    r_ready;
    logic [THREAD_SLOTS-1:0]    r_nv;
    logic [PW-1:0]              r_prio  [THREAD_SLOTS];
    logic [SW-1:0]              r_next  [THREAD_SLOTS];
    logic [SW-1:0]              r_qhead [PRIORITY_LEVELS];
    logic [SW-1:0]              r_qtail [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] r_qne;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic [SW-1:0] tid_idx;
    logic          tid_ok;
    logic          run_rdy;
    logic [PW-1:0] run_prio;
    logic          run_nv;
    logic [SW-1:0] run_next;
    logic          deq_hit;
    logic          free_found;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] enq_slot;
    logic [PW-1:0] enq_q;
    logic [SW-1:0] enq_tail;
    logic          enq_hit;
    logic          sel_found;
    logic [PW-1:0] sel_q;
    logic [PW-1:0] req_prio;

    function automatic logic [PW-1:0] clamp_prio(input logic [3:0] p);
        if (8'(p) >= 8'(PRIORITY_LEVELS)) begin
            return PW'(PRIORITY_LEVELS - 1);
        end
        return PW'(p);
    endfunction

    assign req_prio = clamp_prio(r_req.priority_req);
    assign tid_idx  = SW'(r_req.thread_id);
    assign tid_ok   = (8'(r_req.thread_id) < 8'(THREAD_SLOTS)) && r_used[tid_idx];

    // running thread entry, read in the dequeue step
    assign run_rdy  = r_ready[r_run];
    assign run_prio = r_prio[r_run];
    assign run_nv   = r_nv[r_run];
    assign run_next = r_next[r_run];
    assign deq_hit  = r_run_ok && run_rdy;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = THREAD_SLOTS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_found = 1'b1;
                free_idx   = SW'(k);
            end
        end
    end

    always_comb begin
        case (i_cmd.enq_src)
            SRC_RUN: enq_slot = r_run;
            SRC_NEW: enq_slot = r_new;
            SRC_TID: enq_slot = tid_idx;
            default: enq_slot = r_run;
        endcase
    end

    assign enq_q    = r_prio[enq_slot];
    assign enq_tail = r_qtail[enq_q];
    // a thread already ready keeps its place
    assign enq_hit  = i_cmd.enq && !r_ready[enq_slot];

    always_comb begin
        sel_found = 1'b0;
        sel_q     = '0;
        for (int k = PRIORITY_LEVELS - 1; k >= 0; k--) begin
            if (r_qne[k]) begin
                sel_found = 1'b1;
                sel_q     = PW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= '0;
            r_ret       <= '0;
            r_stat      <= STAT_OK;
            r_new       <= '0;
            r_found     <= 1'b0;
            r_run       <= '0;
            r_run_ok    <= 1'b0;
            r_halt      <= 1'b0;
            r_used      <= '0;
            r_ready     <= '0;
            r_nv        <= '0;
            r_qne       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            for (int k = 0; k < THREAD_SLOTS; k++) begin
                r_prio[k] <= '0;
                r_next[k] <= '0;
            end
            for (int k = 0; k < PRIORITY_LEVELS; k++) begin
                r_qhead[k] <= '0;
                r_qtail[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_req  <= i_in_data;
                r_ret  <= '0;
                r_stat <= STAT_OK;
            end

            if (i_cmd.deq) begin
                if (deq_hit) begin
                    if (run_nv) begin
                        r_qhead[run_prio] <= run_next;
                    end else begin
                        r_qhead[run_prio] <= '0;
                        r_qtail[run_prio] <= '0;
                        r_qne[run_prio]   <= 1'b0;
                    end
                    r_ready[r_run] <= 1'b0;
                    r_nv[r_run]    <= 1'b0;
                    r_next[r_run]  <= '0;
                end
                case (r_req.action)
                    ACT_CREATE: begin
                        r_found <= free_found;
                        r_new   <= free_idx;
                        if (free_found) begin
                            r_used[free_idx]  <= 1'b1;
                            r_prio[free_idx]  <= req_prio;
                            r_ready[free_idx] <= 1'b0;
                            r_nv[free_idx]    <= 1'b0;
                            r_ret             <= 4'(free_idx);
                        end else begin
                            r_stat <= STAT_NOSLOT;
                        end
                    end
                    ACT_EXIT: begin
                        // the running thread is always ready, so the dequeue
                        // above already cleared its queue links
                        if (r_run_ok) begin
                            r_used[r_run] <= 1'b0;
                            r_prio[r_run] <= '0;
                        end
                    end
                    ACT_WAKEUP: begin
                        if (!tid_ok) begin
                            r_stat <= STAT_BADID;
                        end
                    end
                    ACT_GETID: begin
                        if (r_run_ok) begin
                            r_ret <= 4'(r_run);
                        end
                    end
                    ACT_CHPRI: begin
                        if (r_run_ok) begin
                            r_ret <= 4'(run_prio);
                            if (!r_req.priority_keep) begin
                                r_prio[r_run] <= req_prio;
                            end
                        end
                    end
                    default: begin
                        r_ret <= r_ret;
                    end
                endcase
            end

            // append to the tail of the slot's priority queue
            if (enq_hit) begin
                if (r_qne[enq_q]) begin
                    r_next[enq_tail] <= enq_slot;
                    r_nv[enq_tail]   <= 1'b1;
                end else begin
                    r_qhead[enq_q] <= enq_slot;
                    r_qne[enq_q]   <= 1'b1;
                end
                r_qtail[enq_q]    <= enq_slot;
                r_ready[enq_slot] <= 1'b1;
            end

            if (i_cmd.sel) begin
                r_out_valid <= 1'b1;
                if (sel_found) begin
                    r_run                <= r_qhead[sel_q];
                    r_run_ok             <= 1'b1;
                    r_out.running_thread <= 3'(r_qhead[sel_q]);
                    r_out.running_valid  <= 1'b1;
                    r_out.return_value   <= r_ret;
                    r_out.status         <= r_stat;
                end else begin
                    // nothing ready: halt until reset
                    r_halt               <= 1'b1;
                    r_run                <= '0;
                    r_run_ok             <= 1'b0;
                    r_out.running_thread <= '0;
                    r_out.running_valid  <= 1'b0;
                    r_out.return_value   <= '0;
                    r_out.status         <= STAT_HALT;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.action   = r_req.action;
    assign o_status.run_ok   = r_run_ok;
    assign o_status.halted   = r_halt;
    assign o_status.other_ok = (r_req.action == ACT_CREATE) ? r_found : tid_ok;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ----- hdl/priority_ready_queue_scheduler.sv -----
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Fixed-priority FIFO ready-queue thread scheduler, one kernel call a request.
// ---------------------------------------------------------------------------
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_stall  o_out_data (t_out_item)
//
// A request goes from acceptance to a result in the output register through
// these steps: accept, dequeue of the running thread, where needed an enqueue
// step each for the caller and for a created or woken thread, then the select.
// Each step makes at most one queue update on the slot and queue tables.
// A call after a halt goes straight from acceptance to the select step.
// Synchronous reset clears all tables directly; no clearing pass.
// A new request is taken while a result waits; its select step waits for
// the output register to drain.
// ---------------------------------------------------------------------------
module priority_ready_queue_scheduler import prqs_pkg::*; #(
    parameter int THREAD_SLOTS    = DEF_THREAD_SLOTS,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    prqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    prqs_datapath #(
        .THREAD_SLOTS    (THREAD_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/prqs_checker.sv -----
// ---------------------------------------------------------------------------
// prqs_checker
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
module prqs_checker import prqs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    logic r_seen_halt;

    // a halt answer has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_data.status == STAT_HALT) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while a call is in progress");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_halt && o_out_valid |->
            o_out_data.status == STAT_HALT && !o_out_data.running_valid &&
            o_out_data.running_thread == 3'd0 && o_out_data.return_value == 4'd0)
        else $error("scheduler left the halted state");

    a_valid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.running_valid == (o_out_data.status != STAT_HALT)) &&
            (o_out_data.running_valid || o_out_data.running_thread == 3'd0))
        else $error("running_valid disagrees with status");

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
